// File: hw/rtl/hstore_text_tokenizer_macros.svh
// assertion macros for the key-value text tokenizer
// used by the top level only, no other dependencies
`ifndef HSTORE_TEXT_TOKENIZER_MACROS_SVH
`define HSTORE_TEXT_TOKENIZER_MACROS_SVH

// same-cycle implication, checked out of reset
`define HTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// condition that must never hold, checked out of reset
`define HTT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tokenizer forbidden condition");

`endif

// File: hw/rtl/htt_pkg.sv
// shared types and constants for the key-value text tokenizer
// no dependencies
`timescale 1ns / 1ps

package htt_pkg;

  localparam logic [7:0] CH_EQ     = 8'h3D;  // '='
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
  localparam logic [7:0] CH_QUOTE  = 8'h22;  // double quote
  localparam logic [7:0] CH_N      = 8'h6E;  // 'n'
  localparam logic [7:0] CH_U      = 8'h75;  // 'u'
  localparam logic [7:0] CH_L      = 8'h6C;  // 'l'
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] NULL_LEN = 3'd4;
  localparam logic [2:0] NULL_SAT = 3'd7;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_END    = 2'd1,
    ST_SYNTAX = 2'd2
  } status_t;

  typedef enum logic [12:0] {
    PH_WAIT_KEY      = 13'b0000000000001,
    PH_KEY_BARE      = 13'b0000000000010,
    PH_KEY_QUOTE     = 13'b0000000000100,
    PH_KEY_ESC_BARE  = 13'b0000000001000,
    PH_KEY_ESC_QUOTE = 13'b0000000010000,
    PH_WAIT_EQ       = 13'b0000000100000,
    PH_WAIT_GT       = 13'b0000001000000,
    PH_WAIT_VAL      = 13'b0000010000000,
    PH_VAL_BARE      = 13'b0000100000000,
    PH_VAL_QUOTE     = 13'b0001000000000,
    PH_VAL_ESC_BARE  = 13'b0010000000000,
    PH_VAL_ESC_QUOTE = 13'b0100000000000,
    PH_WAIT_DEL      = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_last;
  } in_word_t;

  typedef struct packed {
    logic       content_valid;
    logic       content_in_key;
    logic [7:0] content_byte;
    logic       key_end;
    logic       value_end;
    logic       value_is_null;
    logic       string_end;
    logic [1:0] status;
  } out_word_t;

  // byte class flags, worked out in the front end
  typedef struct packed {
    logic is_space;
    logic is_quote;
    logic is_eq;
    logic is_gt;
    logic is_comma;
    logic is_bslash;
  } byte_cls_t;

  typedef struct packed {
    in_word_t  word;
    byte_cls_t cls;
  } tok_item_t;

  function automatic logic [7:0] null_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = CH_N;
      2'd1:    ch = CH_U;
      default: ch = CH_L;
    endcase
    return ch;
  endfunction

endpackage

// File: hw/rtl/htt_front.sv
// front end: input register and byte classification
// depends on htt_pkg
`timescale 1ns / 1ps

module htt_front import htt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      push_valid,
  input  logic      push_ready,
  output tok_item_t push_item
);

  logic      fr_valid_r, fr_valid_nxt;
  tok_item_t fr_item_r, fr_item_nxt;
  byte_cls_t cls;

  always_comb begin
    cls.is_space  = (in_data.text_byte == 8'h20) ||
                    (in_data.text_byte >= 8'h09 && in_data.text_byte <= 8'h0D);
    cls.is_quote  = in_data.text_byte == CH_QUOTE;
    cls.is_eq     = in_data.text_byte == CH_EQ;
    cls.is_gt     = in_data.text_byte == CH_GT;
    cls.is_comma  = in_data.text_byte == CH_COMMA;
    cls.is_bslash = in_data.text_byte == CH_BSLASH;
  end

  assign in_ready   = !fr_valid_r || push_ready;
  assign push_valid = fr_valid_r;
  assign push_item  = fr_item_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_item_nxt  = fr_item_r;
    if (in_valid && in_ready) begin
      fr_valid_nxt = 1'b1;
      fr_item_nxt  = '{word: in_data, cls: cls};
    end else if (push_ready) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_item_r <= fr_item_nxt;
  end

endmodule

// File: hw/rtl/htt_queue.sv
// short fifo between front end and parser
// depends on htt_pkg
`timescale 1ns / 1ps

module htt_queue import htt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  tok_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output tok_item_t rd_item
);

  tok_item_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]      count_r, count_nxt;
  logic                     push, pop;

  assign wr_ready = count_r != QUEUE_CW'(QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_item  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: hw/rtl/htt_back.sv
// back end: parse state machine and output register
// depends on htt_pkg
`timescale 1ns / 1ps

module htt_back import htt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      rd_valid,
  output logic      rd_ready,
  input  tok_item_t rd_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  phase_t     ph_r, ph_nxt, ph_step;
  status_t    err_r, err_nxt, err_step;
  logic [2:0] ncnt_r, ncnt_nxt, ncnt_base;
  logic       nmatch_r, nmatch_nxt, nmatch_base;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_r, out_nxt;

  logic       pop, last;
  logic [7:0] b;
  byte_cls_t  c;
  logic       cv, ckey, kend, vend, vquoted, null_rst, put_vbare;
  logic       cv_o, ckey_o, kend_o, vend_o, vnull_o;

  assign b        = rd_item.word.text_byte;
  assign last     = rd_item.word.string_last;
  assign c        = rd_item.cls;
  assign rd_ready = !out_valid_r || out_ready;
  assign pop      = rd_valid && rd_ready;

  // token phase step
  always_comb begin
    ph_step   = ph_r;
    err_step  = err_r;
    cv        = 1'b0;
    ckey      = 1'b0;
    kend      = 1'b0;
    vend      = 1'b0;
    vquoted   = 1'b0;
    null_rst  = 1'b0;
    put_vbare = 1'b0;
    unique case (ph_r)
      PH_WAIT_KEY: begin
        if (!c.is_space) begin
          priority if (c.is_quote) begin
            ph_step = PH_KEY_QUOTE;
          end else if (c.is_eq) begin
            err_step = ST_SYNTAX;
          end else if (c.is_bslash) begin
            ph_step = PH_KEY_ESC_BARE;
          end else begin
            ph_step = PH_KEY_BARE;
            cv      = 1'b1;
            ckey    = 1'b1;
          end
        end
      end
      PH_WAIT_VAL: begin
        if (!c.is_space) begin
          null_rst = 1'b1;
          priority if (c.is_quote) begin
            ph_step = PH_VAL_QUOTE;
          end else if (c.is_bslash) begin
            ph_step = PH_VAL_ESC_BARE;
          end else begin
            ph_step   = PH_VAL_BARE;
            cv        = 1'b1;
            put_vbare = 1'b1;
          end
        end
      end
      PH_KEY_BARE: begin
        priority if (c.is_bslash) begin
          ph_step = PH_KEY_ESC_BARE;
        end else if (c.is_eq) begin
          kend    = 1'b1;
          ph_step = PH_WAIT_GT;
          if (last) begin
            ph_step  = PH_WAIT_EQ;
            err_step = ST_END;
          end
        end else if (c.is_space) begin
          kend    = 1'b1;
          ph_step = PH_WAIT_EQ;
        end else begin
          cv   = 1'b1;
          ckey = 1'b1;
        end
      end
      PH_VAL_BARE: begin
        priority if (c.is_bslash) begin
          ph_step = PH_VAL_ESC_BARE;
        end else if (c.is_comma) begin
          vend    = 1'b1;
          ph_step = PH_WAIT_KEY;
        end else if (c.is_space) begin
          vend    = 1'b1;
          ph_step = PH_WAIT_DEL;
        end else begin
          cv        = 1'b1;
          put_vbare = 1'b1;
        end
      end
      PH_KEY_QUOTE: begin
        priority if (c.is_bslash) begin
          ph_step = PH_KEY_ESC_QUOTE;
        end else if (c.is_quote) begin
          kend    = 1'b1;
          ph_step = PH_WAIT_EQ;
        end else begin
          cv   = 1'b1;
          ckey = 1'b1;
        end
      end
      PH_VAL_QUOTE: begin
        priority if (c.is_bslash) begin
          ph_step = PH_VAL_ESC_QUOTE;
        end else if (c.is_quote) begin
          vend    = 1'b1;
          vquoted = 1'b1;
          ph_step = PH_WAIT_DEL;
        end else begin
          cv = 1'b1;
        end
      end
      PH_KEY_ESC_BARE: begin
        cv      = 1'b1;
        ckey    = 1'b1;
        ph_step = PH_KEY_BARE;
      end
      PH_VAL_ESC_BARE: begin
        cv        = 1'b1;
        put_vbare = 1'b1;
        ph_step   = PH_VAL_BARE;
      end
      PH_KEY_ESC_QUOTE: begin
        cv      = 1'b1;
        ckey    = 1'b1;
        ph_step = PH_KEY_QUOTE;
      end
      PH_VAL_ESC_QUOTE: begin
        cv      = 1'b1;
        ph_step = PH_VAL_QUOTE;
      end
      PH_WAIT_EQ: begin
        if (!c.is_space) begin
          priority if (last) begin
            err_step = ST_END;
          end else if (c.is_eq) begin
            ph_step = PH_WAIT_GT;
          end else begin
            err_step = ST_SYNTAX;
          end
        end
      end
      PH_WAIT_GT: begin
        if (c.is_gt) begin
          ph_step = PH_WAIT_VAL;
        end else begin
          err_step = ST_SYNTAX;
        end
      end
      PH_WAIT_DEL: begin
        if (!c.is_space) begin
          if (c.is_comma) begin
            ph_step = PH_WAIT_KEY;
          end else begin
            err_step = ST_SYNTAX;
          end
        end
      end
      default: begin
        err_step = ST_SYNTAX;
      end
    endcase
  end

  // null spelling tracker for bare values
  always_comb begin
    ncnt_base   = null_rst ? 3'd0 : ncnt_r;
    nmatch_base = null_rst ? 1'b1 : nmatch_r;
    ncnt_nxt    = ncnt_base;
    nmatch_nxt  = nmatch_base;
    if (put_vbare) begin
      nmatch_nxt = nmatch_base && (ncnt_base < NULL_LEN) &&
                   ((b | CASE_BIT) == null_char(ncnt_base[1:0]));
      ncnt_nxt   = (ncnt_base == NULL_SAT) ? NULL_SAT : ncnt_base + 3'd1;
    end
  end

  // string end closure, error gating and state return
  always_comb begin
    ph_nxt  = ph_step;
    err_nxt = err_step;
    cv_o    = cv;
    ckey_o  = ckey;
    kend_o  = kend;
    vend_o  = vend;
    vnull_o = vend && !vquoted;
    if (last && err_step == ST_OK) begin
      if (ph_step == PH_KEY_BARE) begin
        kend_o = 1'b1;
        ph_nxt = PH_WAIT_EQ;
      end else if (ph_step == PH_VAL_BARE) begin
        vend_o  = 1'b1;
        vnull_o = 1'b1;
        ph_nxt  = PH_WAIT_DEL;
      end
      if (ph_nxt != PH_WAIT_KEY && ph_nxt != PH_WAIT_DEL) begin
        err_nxt = ST_END;
      end
    end
    if (err_r != ST_OK) begin
      ph_nxt  = ph_r;
      err_nxt = err_r;
      cv_o    = 1'b0;
      ckey_o  = 1'b0;
      kend_o  = 1'b0;
      vend_o  = 1'b0;
    end
    out_nxt.content_valid  = cv_o;
    out_nxt.content_in_key = cv_o && ckey_o;
    out_nxt.content_byte   = cv_o ? b : 8'h00;
    out_nxt.key_end        = kend_o;
    out_nxt.value_end      = vend_o;
    out_nxt.value_is_null  = vend_o && vnull_o && nmatch_nxt && (ncnt_nxt == NULL_LEN);
    out_nxt.string_end     = last;
    out_nxt.status         = err_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_WAIT_KEY;
      err_r       <= ST_OK;
      ncnt_r      <= 3'd0;
      nmatch_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (last) begin
          ph_r     <= PH_WAIT_KEY;
          err_r    <= ST_OK;
          ncnt_r   <= 3'd0;
          nmatch_r <= 1'b1;
        end else begin
          ph_r     <= ph_nxt;
          err_r    <= err_nxt;
          ncnt_r   <= ncnt_nxt;
          nmatch_r <= nmatch_nxt;
        end
      end
    end
    if (pop) begin
      out_r <= out_nxt;
    end
  end

endmodule

// File: hw/rtl/hstore_text_tokenizer.sv
// top level of the key-value text tokenizer
// depends on htt_pkg, htt_front, htt_queue, htt_back and the assertion macro header
`timescale 1ns / 1ps
// key-value text tokenizer, one text word in and one result word out per byte
// input channel in_valid/in_ready/in_data carries a text byte and string_last
// output channel out_valid/out_ready/out_data carries content, end marks,
//   null flag, string end and latched status
// pipeline: input register and byte classifier, a two-entry queue, then the
//   parse state machine feeding the output register
// path: an accepted word goes through the front register, a queue slot and then
//   the output register, which holds the result word
// throughput: one word per cycle, set by the parser updating its phase once per
//   popped word, sustained while out_ready stays high
// when the receiver stalls the output register holds its word, the queue
//   fills, and in_ready drops once the front register cannot drain
// reset (rst_n low, synchronous) empties all stages and returns the parser
//   to waiting for a key with no error latched
// parser state also returns to that point after every string's last byte
// an error latches at the byte that shows it; the rest of that string gives
//   words with status and string end only

module hstore_text_tokenizer import htt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

`include "hstore_text_tokenizer_macros.svh"

  // front register to queue
  logic      push_valid, push_ready;
  tok_item_t push_item;

  // queue to parser
  logic      rd_valid, rd_ready;
  tok_item_t rd_item;

  // classify each accepted word
  htt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouples the front end from parser stalls
  htt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_item  (rd_item)
  );

  // token state machine and output register
  htt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_ready  (rd_ready),
    .rd_item   (rd_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a null flag only rides on a value end mark
  `HTT_ASSERT_IMPL(a_null_with_vend, clk, rst_n, out_valid && out_data.value_is_null, out_data.value_end)
  // a single byte never completes both a key and a value
  `HTT_ASSERT_NEVER(a_one_end_mark, clk, rst_n, out_valid && out_data.key_end && out_data.value_end)
  // no content means cleared content fields
  `HTT_ASSERT_IMPL(a_empty_content, clk, rst_n, out_valid && !out_data.content_valid, out_data.content_byte == 8'h00 && !out_data.content_in_key)

endmodule
